// ----- design/clod_pkg.sv -----
// Package for the cluster LOD cut selector: item types, register indexes and widths.
package clod_pkg;

  localparam int ACC_W = 78;
  localparam int RAD_W = 68;
  localparam int ROOT_W = 34;
  localparam int REM_W = 35;

  localparam logic [2:0] REG_CAM_X = 3'd0;
  localparam logic [2:0] REG_CAM_Y = 3'd1;
  localparam logic [2:0] REG_CAM_Z = 3'd2;
  localparam logic [2:0] REG_NEAR = 3'd3;
  localparam logic [2:0] REG_PROJ = 3'd4;
  localparam logic [2:0] REG_ROWS = 3'd5;
  localparam logic [2:0] REG_LIMIT = 3'd6;
  localparam logic [2:0] REG_CAP = 3'd7;

  localparam logic [16:0] HIT_CEIL = 17'd65536;
  localparam logic [31:0] INF_ERROR = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] own_center_x;
    logic signed [31:0] own_center_y;
    logic signed [31:0] own_center_z;
    logic [30:0]        own_radius;
    logic [31:0]        own_error;
    logic signed [31:0] coarse_center_x;
    logic signed [31:0] coarse_center_y;
    logic signed [31:0] coarse_center_z;
    logic [30:0]        coarse_radius;
    logic [31:0]        coarse_error;
    logic               final_cluster;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cluster_number;
    logic        draw;
    logic        fits;
    logic [16:0] hits_so_far;
    logic        mesh_done;
  } out_item_t;

endpackage

// ----- design/cluster_lod_cut_select.sv -----
// Top level of the cluster LOD cut selector: bit-serial error test of both levels.
// Each item is one mesh cluster. For its own and its coarser level the block squares
// the three center offsets with a one-bit-per-cycle shift-and-add multiplier, each
// after a load state, takes a floor square root two radicand bits per cycle, clamps
// the distance to the near plane and then forms error*projection*rows and near*limit
// on the same serial multiplier. A level with an all-ones error skips all of that.
// The next item is not accepted before the previous one has reached the output
// register, set by the single shared serial multiplier and root unit, and the input
// is stalled while an item is in work. The result waits in an output register, so the
// next item is taken while the previous result is still stalled.
module cluster_lod_cut_select (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clod_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output clod_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_LOAD  = 4'd2;
  localparam logic [3:0] ST_SQ    = 4'd3;
  localparam logic [3:0] ST_SQRT  = 4'd4;
  localparam logic [3:0] ST_NEAR  = 4'd5;
  localparam logic [3:0] ST_MUL1  = 4'd6;
  localparam logic [3:0] ST_MUL2  = 4'd7;
  localparam logic [3:0] ST_MUL3  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  // Configuration registers.
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [30:0]        near_cfg_r, proj_r, limit_r;
  logic [14:0]        rows_r;
  logic [16:0]        cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r    <= '0;
      cam_y_r    <= '0;
      cam_z_r    <= '0;
      near_cfg_r <= 31'd6554;
      proj_r     <= 31'd65536;
      rows_r     <= 15'd1080;
      limit_r    <= 31'd65536;
      cap_r      <= 17'd65536;
    end else if (cfg_we) begin
      case (cfg_idx)
        clod_pkg::REG_CAM_X: cam_x_r    <= cfg_data;
        clod_pkg::REG_CAM_Y: cam_y_r    <= cfg_data;
        clod_pkg::REG_CAM_Z: cam_z_r    <= cfg_data;
        clod_pkg::REG_NEAR:  near_cfg_r <= cfg_data[30:0];
        clod_pkg::REG_PROJ:  proj_r     <= cfg_data[30:0];
        clod_pkg::REG_ROWS:  rows_r     <= cfg_data[14:0];
        clod_pkg::REG_LIMIT: limit_r    <= cfg_data[30:0];
        clod_pkg::REG_CAP:   cap_r      <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  logic [3:0]                   state_r;
  clod_pkg::in_item_t           item_r;
  logic                         met_r;
  logic [1:0]                   axis_r;
  logic [1:0]                   ex_r;
  logic [5:0]                   cnt_r;
  logic [clod_pkg::ACC_W-1:0]   mc_r, acc_r, lhs_r;
  logic [32:0]                  mp_r;
  logic [clod_pkg::RAD_W-1:0]   rad_r;
  logic [clod_pkg::REM_W-1:0]   rem_r;
  logic [clod_pkg::ROOT_W-1:0]  root_r;
  logic [33:0]                  near_r;
  logic [15:0]                  idx_r;
  logic [16:0]                  hit_r;
  logic                         out_valid_r;
  clod_pkg::out_item_t          out_r;

  // Fields of the level under test.
  logic signed [31:0] cen;
  logic signed [31:0] cam;
  logic [30:0]        radius;
  logic [31:0]        err;
  logic signed [32:0] diff;
  logic [32:0]        mag;

  always_comb begin
    case (axis_r)
      2'd0:    begin
        cen = met_r ? item_r.coarse_center_x : item_r.own_center_x;
        cam = cam_x_r;
      end
      2'd1:    begin
        cen = met_r ? item_r.coarse_center_y : item_r.own_center_y;
        cam = cam_y_r;
      end
      default: begin
        cen = met_r ? item_r.coarse_center_z : item_r.own_center_z;
        cam = cam_z_r;
      end
    endcase
    radius = met_r ? item_r.coarse_radius : item_r.own_radius;
    err    = met_r ? item_r.coarse_error : item_r.own_error;
    diff   = 33'(cen) - 33'(cam);
    mag    = diff[32] ? 33'(-diff) : 33'(diff);
  end

  // One step of the serial multiplier.
  logic [clod_pkg::ACC_W-1:0] acc_nxt;
  assign acc_nxt = acc_r + (mp_r[0] ? mc_r : '0);

  // One step of the square root, two radicand bits per cycle.
  logic [clod_pkg::REM_W+1:0] rem2, trial;
  logic                       take;
  assign rem2  = {rem_r, rad_r[clod_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign take  = rem2 >= trial;

  // Near distance with clamp; the distance minus the radius may be negative.
  logic signed [35:0] near_raw;
  logic [30:0]        near_min;
  assign near_raw = 36'(root_r) - 36'(radius);
  assign near_min = (near_cfg_r == '0) ? 31'd1 : near_cfg_r;

  logic [clod_pkg::ACC_W:0] rhs;
  assign rhs = {acc_nxt, 1'b0};

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  logic draw, fits;
  assign draw = !ex_r[0] && ex_r[1];
  assign fits = draw && (hit_r < cap_r);

  // The result register is loaded as the finish state ends and stays full until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      hit_r       <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            met_r   <= 1'b0;
            state_r <= ST_START;
          end
        end
        ST_START: begin
          if (err == clod_pkg::INF_ERROR) begin
            ex_r[met_r] <= 1'b1;
            met_r       <= 1'b1;
            state_r     <= met_r ? ST_FIN : ST_START;
          end else begin
            axis_r  <= 2'd0;
            acc_r   <= '0;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          mc_r    <= clod_pkg::ACC_W'(mag);
          mp_r    <= mag;
          cnt_r   <= 6'd33;
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          if (cnt_r == 6'd1) begin
            if (axis_r == 2'd2) begin
              rad_r   <= clod_pkg::RAD_W'(acc_nxt);
              rem_r   <= '0;
              root_r  <= '0;
              cnt_r   <= 6'(clod_pkg::ROOT_W);
              state_r <= ST_SQRT;
            end else begin
              acc_r   <= acc_nxt;
              axis_r  <= axis_r + 2'd1;
              state_r <= ST_LOAD;
            end
          end else begin
            acc_r <= acc_nxt;
            mc_r  <= mc_r << 1;
            mp_r  <= mp_r >> 1;
            cnt_r <= cnt_r - 6'd1;
          end
        end
        ST_SQRT: begin
          rem_r  <= take ? clod_pkg::REM_W'(rem2 - trial) : clod_pkg::REM_W'(rem2);
          root_r <= {root_r[clod_pkg::ROOT_W-2:0], take};
          rad_r  <= rad_r << 2;
          cnt_r  <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) state_r <= ST_NEAR;
        end
        ST_NEAR: begin
          near_r  <= (near_raw > $signed(36'(near_min))) ? near_raw[33:0] : 34'(near_min);
          mc_r    <= clod_pkg::ACC_W'(err);
          mp_r    <= 33'(proj_r);
          acc_r   <= '0;
          cnt_r   <= 6'd31;
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          if (cnt_r == 6'd1) begin
            mc_r    <= acc_nxt;
            mp_r    <= 33'(rows_r);
            acc_r   <= '0;
            cnt_r   <= 6'd15;
            state_r <= ST_MUL2;
          end else begin
            acc_r <= acc_nxt;
            mc_r  <= mc_r << 1;
            mp_r  <= mp_r >> 1;
            cnt_r <= cnt_r - 6'd1;
          end
        end
        ST_MUL2: begin
          if (cnt_r == 6'd1) begin
            lhs_r   <= acc_nxt;
            mc_r    <= clod_pkg::ACC_W'(near_r);
            mp_r    <= 33'(limit_r);
            acc_r   <= '0;
            cnt_r   <= 6'd31;
            state_r <= ST_MUL3;
          end else begin
            acc_r <= acc_nxt;
            mc_r  <= mc_r << 1;
            mp_r  <= mp_r >> 1;
            cnt_r <= cnt_r - 6'd1;
          end
        end
        ST_MUL3: begin
          if (cnt_r == 6'd1) begin
            // The right side carries the factor of two from the halved projection.
            ex_r[met_r] <= {1'b0, lhs_r} > rhs;
            met_r       <= 1'b1;
            state_r     <= met_r ? ST_FIN : ST_START;
          end else begin
            acc_r <= acc_nxt;
            mc_r  <= mc_r << 1;
            mp_r  <= mp_r >> 1;
            cnt_r <= cnt_r - 6'd1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_r.cluster_number <= idx_r;
            out_r.draw           <= draw;
            out_r.fits           <= fits;
            out_r.hits_so_far    <= (draw && hit_r < clod_pkg::HIT_CEIL) ? hit_r + 17'd1
                                                                         : hit_r;
            out_r.mesh_done      <= item_r.final_cluster;
            if (item_r.final_cluster) begin
              idx_r <= '0;
              hit_r <= '0;
            end else begin
              idx_r <= idx_r + 16'd1;
              if (draw && hit_r < clod_pkg::HIT_CEIL) hit_r <= hit_r + 17'd1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
